// File: src/echo_wave_leader_election_core_assert.svh
// Assertion macros used by the checker file.
`ifndef ECHO_WAVE_LEADER_ELECTION_CORE_ASSERT_SVH
`define ECHO_WAVE_LEADER_ELECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define EWLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ewle assertion failed");

// Next-cycle implication, disabled while reset is high.
`define EWLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ewle assertion failed");

`endif

// File: src/ewle_pkg.sv
package ewle_pkg;

   // Width of identity fields on the channels
   localparam int FIELD_ID_W = 64;

   // Commands
   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_ELECTION = 2'd1;
   localparam logic [1:0] CMD_LEADER   = 2'd2;

   // Send actions
   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_ELECT_ALL    = 3'd1;
   localparam logic [2:0] ACT_ELECT_OTHERS = 3'd2;
   localparam logic [2:0] ACT_ELECT_FATHER = 3'd3;
   localparam logic [2:0] ACT_LEADER_ALL   = 3'd4;

   // Register indexes
   localparam logic CSR_OWN_ID         = 1'b0;
   localparam logic CSR_NEIGHBOR_COUNT = 1'b1;

   // Saturation point of both message counters
   localparam logic [7:0] COUNT_MAX = 8'd255;

   // Up to two send actions plus the status shared by both
   typedef struct packed {
      logic [2:0]            act0;
      logic [FIELD_ID_W-1:0] id0;
      logic [2:0]            act1;
      logic [FIELD_ID_W-1:0] id1;
      logic                  two;
      logic [FIELD_ID_W-1:0] father;
      logic                  finished;
      logic                  won;
      logic [FIELD_ID_W-1:0] leader;
      logic                  leader_known;
   } ewle_result_type;

endpackage

// File: src/ewle_if.sv
interface ewle_req_if import ewle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [FIELD_ID_W-1:0] msg_id;
   logic [FIELD_ID_W-1:0] sender_id;

   modport source (output valid, cmd, msg_id, sender_id, input ready);
   modport sink (input valid, cmd, msg_id, sender_id, output ready);
endinterface

interface ewle_rsp_if import ewle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            action;
   logic [FIELD_ID_W-1:0] send_id;
   logic [FIELD_ID_W-1:0] father_out;
   logic                  last;
   logic                  finished;
   logic                  won;
   logic [FIELD_ID_W-1:0] leader_out;
   logic                  leader_known;

   modport source (output valid, action, send_id, father_out, last, finished, won,
                   leader_out, leader_known, input ready);
   modport sink (input valid, action, send_id, father_out, last, finished, won,
                 leader_out, leader_known, output ready);
endinterface

// File: src/ewle_node.sv
module ewle_node import ewle_pkg::*; #(
   parameter int ID_WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ID_WIDTH-1:0] own_id,
   input  logic [7:0]          neighbor_count,
   input  logic                commit,
   input  logic [1:0]          cmd,
   input  logic [ID_WIDTH-1:0] msg_id,
   input  logic [ID_WIDTH-1:0] sender_id,
   output ewle_result_type     result
);

   logic [ID_WIDTH-1:0] wave_id_ff, wave_id_in;
   logic                wave_valid_ff, wave_valid_in;
   logic [ID_WIDTH-1:0] father_id_ff, father_id_in;
   logic [7:0]          election_count_ff, election_count_in;
   logic [7:0]          ldr_tally_ff, ldr_tally_in;
   logic [ID_WIDTH-1:0] leader_id_ff, leader_id_in;
   logic                leader_valid_ff, leader_valid_in;
   logic                won_flag_ff, won_flag_in;

   logic                restart;
   logic [7:0]          count_base;
   logic [2:0]          echo_act;

   // Work out the new node state and the send actions for the held message
   always_comb begin
      wave_id_in        = wave_id_ff;
      wave_valid_in     = wave_valid_ff;
      father_id_in      = father_id_ff;
      election_count_in = election_count_ff;
      ldr_tally_in      = ldr_tally_ff;
      leader_id_in      = leader_id_ff;
      leader_valid_in   = leader_valid_ff;
      won_flag_in       = won_flag_ff;
      restart           = 1'b0;
      count_base        = election_count_ff;
      echo_act          = ACT_NONE;
      result            = '0;

      case (cmd)
         CMD_START: begin
            wave_id_in    = own_id;
            wave_valid_in = 1'b1;
            result.act0   = ACT_ELECT_ALL;
            result.id0    = FIELD_ID_W'(own_id);
         end
         CMD_ELECTION: begin
            // Lower wave or no wave: extinguish the old one and adopt the sender
            restart = !wave_valid_ff || (msg_id < wave_id_ff);
            if (restart) begin
               wave_id_in      = msg_id;
               wave_valid_in   = 1'b1;
               count_base      = '0;
               ldr_tally_in    = '0;
               leader_id_in    = '0;
               leader_valid_in = 1'b0;
               father_id_in    = sender_id;
               result.act0     = ACT_ELECT_OTHERS;
               result.id0      = FIELD_ID_W'(msg_id);
            end
            // Count a message of the active wave, echo or announce on the last
            if ((msg_id == wave_id_in) && (count_base < COUNT_MAX)) begin
               election_count_in = count_base + 8'd1;
               if (election_count_in == neighbor_count) begin
                  echo_act = (wave_id_in == own_id) ? ACT_LEADER_ALL : ACT_ELECT_FATHER;
                  if (restart) begin
                     result.act1 = echo_act;
                     result.id1  = FIELD_ID_W'(msg_id);
                     result.two  = 1'b1;
                  end else begin
                     result.act0 = echo_act;
                     result.id0  = FIELD_ID_W'(msg_id);
                  end
               end
            end else begin
               election_count_in = count_base;
            end
         end
         CMD_LEADER: begin
            // Relay the first leader message only
            if (ldr_tally_ff == '0) begin
               result.act0 = ACT_LEADER_ALL;
               result.id0  = FIELD_ID_W'(msg_id);
            end
            ldr_tally_in    = (ldr_tally_ff < COUNT_MAX) ?
                              ldr_tally_ff + 8'd1 : ldr_tally_ff;
            leader_id_in    = msg_id;
            leader_valid_in = 1'b1;
         end
         default: begin
         end
      endcase

      // Conclusion check on every election or leader message
      if ((cmd != CMD_START) && (ldr_tally_in == neighbor_count)) begin
         won_flag_in     = leader_valid_in && (leader_id_in == own_id);
         wave_valid_in   = 1'b0;
         result.finished = 1'b1;
      end

      result.father       = FIELD_ID_W'(father_id_in);
      result.won          = won_flag_in && leader_valid_in;
      result.leader       = FIELD_ID_W'(leader_id_in);
      result.leader_known = leader_valid_in;
   end

   // Commit the new state when the message moves on to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_id_ff        <= '0;
         wave_valid_ff     <= 1'b0;
         father_id_ff      <= '0;
         election_count_ff <= '0;
         ldr_tally_ff      <= '0;
         leader_id_ff      <= '0;
         leader_valid_ff   <= 1'b0;
         won_flag_ff       <= 1'b0;
      end else if (commit) begin
         wave_id_ff        <= wave_id_in;
         wave_valid_ff     <= wave_valid_in;
         father_id_ff      <= father_id_in;
         election_count_ff <= election_count_in;
         ldr_tally_ff      <= ldr_tally_in;
         leader_id_ff      <= leader_id_in;
         leader_valid_ff   <= leader_valid_in;
         won_flag_ff       <= won_flag_in;
      end
   end

endmodule

// File: src/ewle_out.sv
module ewle_out import ewle_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ewle_result_type result,
   input  logic            load,
   output logic            free,
   ewle_rsp_if.source      rsp
);

   ewle_result_type res_ff, res_in;
   logic            valid_ff, valid_in;
   logic            sel_ff, sel_in;
   logic            last_now;
   logic            taken;

   assign last_now = !res_ff.two || sel_ff;
   assign taken    = valid_ff && rsp.ready;
   assign free     = !valid_ff || (rsp.ready && last_now);

   // Load a fresh pair, step to the second action, or drop after the last transfer
   always_comb begin
      res_in   = res_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         res_in   = result;
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (taken) begin
         if (last_now) begin
            valid_in = 1'b0;
         end else begin
            sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      res_ff <= res_in;
   end

   // Present the selected action with the shared status
   assign rsp.valid        = valid_ff;
   assign rsp.action       = sel_ff ? res_ff.act1 : res_ff.act0;
   assign rsp.send_id      = sel_ff ? res_ff.id1 : res_ff.id0;
   assign rsp.father_out   = res_ff.father;
   assign rsp.last         = last_now;
   assign rsp.finished     = res_ff.finished;
   assign rsp.won          = res_ff.won;
   assign rsp.leader_out   = res_ff.leader;
   assign rsp.leader_known = res_ff.leader_known;

endmodule

// File: src/echo_wave_leader_election_core.sv
// One node of a lowest-identity-wins echo election with extinction.
// req channel: one message per transfer (cmd: start, election or leader
//   received; msg_id carries the wave or leader identity, sender_id the peer).
// rsp channel: one or two send actions per message, in order; last marks the
//   final one. Father, leader and finished/won status ride on every action.
// csr port: write own_id (index 0) and neighbor_count (index 1) while idle.
// Path: a message accepted on req waits in the input register, is
//   evaluated against the node state and loaded into the result register,
//   from which its first action is offered on rsp.
// Throughput: one message per cycle when each yields a single action and
//   rsp does not stall; a message with two actions holds the result register
//   until both have transferred, since the rsp port moves one action per cycle.
// Reset clears the node state, the configuration registers and the valid flags of the input and result registers.
// When rsp stalls, the result register holds, the input register fills and
//   req.ready drops; nothing is lost or repeated.
module echo_wave_leader_election_core import ewle_pkg::*; #(
   parameter int ID_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   ewle_req_if.sink              req,
   ewle_rsp_if.source            rsp,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [FIELD_ID_W-1:0] csr_wdata
);

   logic [ID_WIDTH-1:0] own_id_ff, own_id_in;
   logic [7:0]          neighbor_count_ff, neighbor_count_in;

   logic                item_valid_ff, item_valid_in;
   logic [1:0]          item_cmd_ff, item_cmd_in;
   logic [ID_WIDTH-1:0] item_msg_ff, item_msg_in;
   logic [ID_WIDTH-1:0] item_sender_ff, item_sender_in;

   logic                out_free;
   logic                advance;
   logic                accept;
   ewle_result_type     result;

   // Configuration writes
   always_comb begin
      own_id_in         = own_id_ff;
      neighbor_count_in = neighbor_count_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OWN_ID:         own_id_in = csr_wdata[ID_WIDTH-1:0];
            CSR_NEIGHBOR_COUNT: neighbor_count_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: take a transfer when empty or when its item moves on
   assign advance   = item_valid_ff && out_free;
   assign req.ready = !item_valid_ff || out_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      item_valid_in  = item_valid_ff;
      item_cmd_in    = item_cmd_ff;
      item_msg_in    = item_msg_ff;
      item_sender_in = item_sender_ff;
      if (accept) begin
         item_valid_in  = 1'b1;
         item_cmd_in    = req.cmd;
         item_msg_in    = req.msg_id[ID_WIDTH-1:0];
         item_sender_in = req.sender_id[ID_WIDTH-1:0];
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff         <= '0;
         neighbor_count_ff <= '0;
         item_valid_ff     <= 1'b0;
      end else begin
         own_id_ff         <= own_id_in;
         neighbor_count_ff <= neighbor_count_in;
         item_valid_ff     <= item_valid_in;
      end
      item_cmd_ff    <= item_cmd_in;
      item_msg_ff    <= item_msg_in;
      item_sender_ff <= item_sender_in;
   end

   ewle_node #(
      .ID_WIDTH (ID_WIDTH)
   ) u_node (
      .clock          (clock),
      .reset          (reset),
      .own_id         (own_id_ff),
      .neighbor_count (neighbor_count_ff),
      .commit         (advance),
      .cmd            (item_cmd_ff),
      .msg_id         (item_msg_ff),
      .sender_id      (item_sender_ff),
      .result         (result)
   );

   ewle_out u_out (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .load   (advance),
      .free   (out_free),
      .rsp    (rsp)
   );

endmodule

// File: src/ewle_checker.sv
`include "echo_wave_leader_election_core_assert.svh"

module ewle_checker import ewle_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            rsp_action,
   input logic [FIELD_ID_W-1:0] rsp_send_id,
   input logic                  rsp_last,
   input logic                  rsp_won,
   input logic                  rsp_leader_known
);

   // A stalled action holds
   `EWLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action) && $stable(rsp_send_id))

   // The second action of a message follows its first without a gap
   `EWLE_ASSERT_NEXT(a_second_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

   // An empty action stands alone and carries no identity
   `EWLE_ASSERT_NOW(a_none_alone, clock, reset, rsp_valid && (rsp_action == ACT_NONE), rsp_last && (rsp_send_id == '0))

   // Winning needs a known leader
   `EWLE_ASSERT_NOW(a_won_known, clock, reset, rsp_valid && rsp_won, rsp_leader_known)

endmodule

bind echo_wave_leader_election_core ewle_checker u_ewle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_action       (rsp.action),
   .rsp_send_id      (rsp.send_id),
   .rsp_last         (rsp.last),
   .rsp_won          (rsp.won),
   .rsp_leader_known (rsp.leader_known)
);
